>>> src/drff_pkg.sv
`timescale 1ns / 1ps
package drff_pkg;

    // Configuration register indexes
    localparam logic CFG_CLIENT_MAC = 1'b0;
    localparam logic CFG_XID        = 1'b1;

    // Frame offsets and lengths in bytes
    localparam int unsigned POS_ETYPE_HI  = 12;
    localparam int unsigned POS_ETYPE_LO  = 13;
    localparam int unsigned POS_IP_VER    = 14;
    localparam int unsigned POS_IP_FIRST  = 15;
    localparam int unsigned POS_IP_PROTO  = 23;
    localparam int unsigned ETH_HDR_LEN   = 14;
    localparam int unsigned UDP_HDR_LEN   = 8;
    localparam int unsigned MIN_FRAME_LEN = 282;
    localparam int unsigned MIN_LEN_BASE  = 262;

    // Offsets inside the DHCP payload
    localparam int unsigned DHCP_XID_LO    = 4;
    localparam int unsigned DHCP_XID_HI    = 8;
    localparam int unsigned DHCP_YIADDR_LO = 16;
    localparam int unsigned DHCP_YIADDR_HI = 20;
    localparam int unsigned DHCP_CHADDR_LO = 28;
    localparam int unsigned DHCP_CHADDR_HI = 34;
    localparam int unsigned DHCP_MAGIC_LO  = 236;
    localparam int unsigned DHCP_OPTS_LO   = 240;

    // Field values
    localparam logic [7:0]  ETYPE_IPV4_HI = 8'h08;
    localparam logic [7:0]  ETYPE_IPV4_LO = 8'h00;
    localparam logic [3:0]  IP_VERSION_4  = 4'd4;
    localparam logic [3:0]  IP_IHL_MIN    = 4'd5;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
    localparam logic [7:0]  UDP_SPORT_LO  = 8'd67;
    localparam logic [7:0]  UDP_DPORT_LO  = 8'd68;
    localparam logic [7:0]  DHCP_OP_REPLY = 8'd2;
    localparam logic [31:0] DHCP_MAGIC    = 32'h63825363;

    // Option codes
    localparam logic [7:0] OPT_PAD       = 8'd0;
    localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
    localparam logic [7:0] OPT_SERVER_ID = 8'd54;
    localparam logic [7:0] OPT_END       = 8'd255;
    localparam logic [7:0] OPT_SID_LEN   = 8'd4;

    // Message types
    localparam logic [7:0] MSG_OFFER = 8'd2;
    localparam logic [7:0] MSG_ACK   = 8'd5;

    typedef enum logic [1:0] {
        PH_CODE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_FIRST = 2'd2,
        PH_REST  = 2'd3
    } t_opt_phase;

    typedef struct packed {
        logic [7:0]  type_seen;
        logic [31:0] server_seen;
    } t_opt_view;

endpackage

>>> src/drff_opt_walk.sv
`timescale 1ns / 1ps
module drff_opt_walk
    import drff_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_clear,
    input  logic [7:0] i_byte,
    output t_opt_view  o_next
);

    t_opt_phase  r_phase, n_phase;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_left, n_left;
    logic [31:0] r_pend, n_pend;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_srv, n_srv;
    logic        r_ended, n_ended;
    logic [7:0]  left_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase <= PH_CODE;
            r_code  <= '0;
            r_left  <= '0;
            r_pend  <= '0;
            r_type  <= '0;
            r_srv   <= '0;
            r_ended <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_code  <= n_code;
            r_left  <= n_left;
            r_pend  <= n_pend;
            r_type  <= n_type;
            r_srv   <= n_srv;
            r_ended <= n_ended;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_code   = r_code;
        n_left   = r_left;
        n_pend   = r_pend;
        n_type   = r_type;
        n_srv    = r_srv;
        n_ended  = r_ended;
        left_dec = r_left - 8'd1;
        if (!r_ended) begin
            case (r_phase)
                PH_CODE: begin
                    if (i_byte == OPT_END) begin
                        n_ended = 1'b1;
                    end else if (i_byte != OPT_PAD) begin
                        n_code  = i_byte;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_left = i_byte;
                    if (i_byte == 8'd0) begin
                        n_phase = PH_CODE;
                    end else begin
                        // forget codes whose value is not kept
                        if (!(r_code == OPT_MSG_TYPE ||
                              (r_code == OPT_SERVER_ID && i_byte == OPT_SID_LEN))) begin
                            n_code = '0;
                        end
                        n_pend  = '0;
                        n_phase = PH_FIRST;
                    end
                end
                default: begin
                    if (r_code == OPT_MSG_TYPE && r_phase == PH_FIRST) begin
                        n_pend = {24'd0, i_byte};
                    end else if (r_code == OPT_SERVER_ID) begin
                        n_pend = {r_pend[23:0], i_byte};
                    end
                    n_phase = PH_REST;
                    n_left  = left_dec;
                    if (left_dec == 8'd0) begin
                        if (r_code == OPT_MSG_TYPE) begin
                            n_type = n_pend[7:0];
                        end else if (r_code == OPT_SERVER_ID) begin
                            n_srv = n_pend;
                        end
                        n_phase = PH_CODE;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_next.type_seen   = i_step ? n_type : r_type;
        o_next.server_seen = i_step ? n_srv : r_srv;
    end

endmodule

>>> src/dhcp_reply_frame_filter_core.sv
`timescale 1ns / 1ps
// DHCP reply frame filter.
// Slave stream: one frame byte per item in s_axis_tdata, s_axis_tlast on the
// final byte. Master stream: one verdict item per frame, sent after the byte
// marked last. m_axis_tuser carries frame_accepted; when it is 0 all of
// m_axis_tdata is 0. Config channel: index 0 writes the client MAC,
// index 1 the transaction id; write only while no frame is in flight.
// Throughput: one byte per clock while s_axis_tready is high; each byte updates
// the header checks and the option walker in the cycle it is accepted. The
// registered verdict appears on the master side the cycle after the last byte.
// A single output register decouples the two sides: s_axis_tready stays high
// while that register is empty or being drained in the same cycle, and drops
// only while a verdict waits on a stalled receiver.
// Bytes past MAX_FRAME are consumed but ignored; the length counts MAX_FRAME.
// Reset clears the frame state, both config registers and the output valid;
// a partial frame at reset is dropped.
module dhcp_reply_frame_filter_core
    import drff_pkg::*;
#(
    parameter int MAX_FRAME = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] message_type, [8] server_found, [9] server_id_present,
    // [41:10] server_id, [73:42] offered_addr, [79:74] zero
    output logic [79:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser,   // frame_accepted
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    localparam int PW = $clog2(MAX_FRAME + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_FRAME);

    logic [PW-1:0] r_pos, n_pos;
    logic [5:0]    r_hlen, n_hlen;
    logic          r_rej, n_rej;
    logic [31:0]   r_offer, n_offer;
    logic [47:0]   r_mac;
    logic [31:0]   r_xid;

    logic          r_out_valid;
    logic [79:0]   r_out_data;
    logic          r_out_acc;

    logic          in_acc, last_acc, walk_en, verdict_ok;
    logic [7:0]    b;
    logic [6:0]    udp_off, dhcp_off;
    logic [PW-1:0] rel;
    logic [1:0]    sel4;
    logic [2:0]    sel6;
    t_opt_view     opt_next;

    assign b           = i_s_axis_tdata;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign last_acc    = in_acc && i_s_axis_tlast;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac <= '0;
            r_xid <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CLIENT_MAC: r_mac <= i_cfg_data;
                CFG_XID:        r_xid <= i_cfg_data[31:0];
                default:        ;
            endcase
        end
    end

    // Per-byte header checks, offered-address capture and option-walker enable
    always_comb begin
        n_pos    = r_pos;
        n_hlen   = r_hlen;
        n_rej    = r_rej;
        n_offer  = r_offer;
        walk_en  = 1'b0;
        udp_off  = 7'(ETH_HDR_LEN) + {1'b0, r_hlen};
        dhcp_off = udp_off + 7'(UDP_HDR_LEN);
        rel      = '0;
        sel4     = '0;
        sel6     = '0;
        if (r_pos < POS_MAX) begin
            n_pos = r_pos + PW'(1);
            if (r_pos == PW'(POS_ETYPE_HI)) begin
                if (b != ETYPE_IPV4_HI) n_rej = 1'b1;
            end else if (r_pos == PW'(POS_ETYPE_LO)) begin
                if (b != ETYPE_IPV4_LO) n_rej = 1'b1;
            end else if (r_pos == PW'(POS_IP_VER)) begin
                if (b[7:4] != IP_VERSION_4 || b[3:0] < IP_IHL_MIN) n_rej = 1'b1;
                n_hlen = {b[3:0], 2'b00};
            end else if (r_pos >= PW'(POS_IP_FIRST)) begin
                if (r_pos == PW'(POS_IP_PROTO) && b != IP_PROTO_UDP) n_rej = 1'b1;
                if (r_pos >= PW'(udp_off) && r_pos < PW'(dhcp_off)) begin
                    rel = r_pos - PW'(udp_off);
                    case (rel[2:0])
                        3'd0, 3'd2: if (b != 8'd0) n_rej = 1'b1;
                        3'd1:       if (b != UDP_SPORT_LO) n_rej = 1'b1;
                        3'd3:       if (b != UDP_DPORT_LO) n_rej = 1'b1;
                        default:    ;
                    endcase
                end else if (r_pos >= PW'(dhcp_off)) begin
                    rel  = r_pos - PW'(dhcp_off);
                    sel4 = 2'd3 - rel[1:0];
                    sel6 = 3'd5 - (rel[2:0] - 3'd4);
                    if (rel == '0) begin
                        if (b != DHCP_OP_REPLY) n_rej = 1'b1;
                    end else if (rel >= PW'(DHCP_XID_LO) && rel < PW'(DHCP_XID_HI)) begin
                        if (b != r_xid[{sel4, 3'b000} +: 8]) n_rej = 1'b1;
                    end else if (rel >= PW'(DHCP_YIADDR_LO) &&
                                 rel < PW'(DHCP_YIADDR_HI)) begin
                        n_offer = {r_offer[23:0], b};
                    end else if (rel >= PW'(DHCP_CHADDR_LO) &&
                                 rel < PW'(DHCP_CHADDR_HI)) begin
                        if (b != r_mac[{sel6, 3'b000} +: 8]) n_rej = 1'b1;
                    end else if (rel >= PW'(DHCP_MAGIC_LO) &&
                                 rel < PW'(DHCP_OPTS_LO)) begin
                        if (b != DHCP_MAGIC[{sel4, 3'b000} +: 8]) n_rej = 1'b1;
                    end else if (rel >= PW'(DHCP_OPTS_LO)) begin
                        walk_en = 1'b1;
                    end
                end
            end
        end
    end

    drff_opt_walk u_opt_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_acc && walk_en),
        .i_clear (last_acc),
        .i_byte  (b),
        .o_next  (opt_next)
    );

    assign verdict_ok = !n_rej && n_pos >= PW'(MIN_FRAME_LEN) &&
                        n_pos >= PW'(MIN_LEN_BASE) + PW'(n_hlen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || last_acc) begin
            r_pos   <= '0;
            r_hlen  <= '0;
            r_rej   <= 1'b0;
            r_offer <= '0;
        end else if (in_acc) begin
            r_pos   <= n_pos;
            r_hlen  <= n_hlen;
            r_rej   <= n_rej;
            r_offer <= n_offer;
        end
    end

    // Hold the verdict until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (last_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (last_acc) begin
            r_out_acc <= verdict_ok;
            if (verdict_ok) begin
                r_out_data <= {6'd0, n_offer, opt_next.server_seen,
                               opt_next.server_seen != 32'd0,
                               opt_next.type_seen == MSG_OFFER ||
                               opt_next.type_seen == MSG_ACK,
                               opt_next.type_seen};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_acc;

endmodule

>>> src/drff_checker.sv
`timescale 1ns / 1ps
module drff_checker
    import drff_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [79:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // A stalled verdict holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("verdict changed while stalled");

    // A new verdict follows an accepted last byte
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !$past(o_m_axis_tvalid && !i_m_axis_tready) |->
            $past(i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast))
        else $error("verdict without a last byte");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == 80'd0)
        else $error("rejected frame carries data");

    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[8] == (o_m_axis_tdata[7:0] == MSG_OFFER ||
                                  o_m_axis_tdata[7:0] == MSG_ACK))
        else $error("server_found disagrees with message type");

    a_sid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[9] == (o_m_axis_tdata[41:10] != 32'd0))
        else $error("server_id_present disagrees with server id");

endmodule

bind dhcp_reply_frame_filter_core drff_checker u_drff_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
